@@ design/c39_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package c39_pkg;

    // Configuration register indexes
    localparam logic CFG_NARROW = 1'b0;
    localparam logic CFG_WIDE   = 1'b1;

    // Message state codes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_OPEN    = 2'd1;
    localparam logic [1:0] MODE_DISCARD = 2'd2;

    // Sequencer phases
    localparam logic [1:0] PH_ERR   = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_CHAR  = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    localparam int NUM_SYMBOLS = 44;
    localparam logic [5:0] STAR_INDEX = 6'd43;
    localparam logic [3:0] LAST_ELEM = 4'd8;
    localparam logic [3:0] GAP_ELEM  = 4'd9;

    // Wide flags of the nine elements, first element in the top bit
    localparam logic [8:0] C39_PATTERNS [NUM_SYMBOLS] = '{
        9'b000110100, 9'b100100001, 9'b001100001, 9'b101100000, 9'b000110001,
        9'b100110000, 9'b001110000, 9'b000100101, 9'b100100100, 9'b001100100,
        9'b100001001, 9'b001001001, 9'b101001000, 9'b000011001, 9'b100011000,
        9'b001011000, 9'b000001101, 9'b100001100, 9'b001001100, 9'b000011100,
        9'b100000011, 9'b001000011, 9'b101000010, 9'b000010011, 9'b100010010,
        9'b001010010, 9'b000000111, 9'b100000110, 9'b001000110, 9'b000010110,
        9'b110000001, 9'b011000001, 9'b111000000, 9'b010010001, 9'b110010000,
        9'b011010000, 9'b010000101, 9'b110000100, 9'b011000100, 9'b010101000,
        9'b010100010, 9'b010001010, 9'b000101010, 9'b010010100
    };

    localparam logic [8:0] STAR_PATTERN = C39_PATTERNS[STAR_INDEX];

    // One decoded character waiting for the sequencer
    typedef struct packed {
        logic       bad;
        logic       start;
        logic       stop;
        logic [8:0] pat;
    } c39_job_t;

    // One output element
    typedef struct packed {
        logic       is_bar;
        logic       is_wide;
        logic [7:0] width_px;
        logic       last_of_run;
        logic       symbol_done;
        logic       bad_char;
    } c39_elem_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] index;
    } c39_index_t;

    // Map an ASCII code to its symbol table entry
    function automatic c39_index_t c39_char_index(input logic [7:0] c);
        c39_index_t r;
        r.valid = 1'b1;
        r.index = 6'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.index = 6'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            r.index = 6'(c - 8'h41) + 6'd10;
        end else begin
            case (c)
                8'h2D:   r.index = 6'd36;
                8'h2E:   r.index = 6'd37;
                8'h20:   r.index = 6'd38;
                8'h24:   r.index = 6'd39;
                8'h2F:   r.index = 6'd40;
                8'h2B:   r.index = 6'd41;
                8'h25:   r.index = 6'd42;
                8'h2A:   r.index = 6'd43;
                default: r.valid = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/c39_elem_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module c39_elem_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  wire c39_pkg::c39_job_t job,
    output logic                  job_take,
    input  wire logic [7:0]       narrow_width,
    input  wire logic [7:0]       wide_width,
    output logic                  elem_valid,
    output c39_pkg::c39_elem_t    elem,
    input  wire logic             elem_ready
);
    import c39_pkg::*;

    logic       busy_reg, busy_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] idx_reg, idx_next;
    logic [8:0] pat_reg;
    logic       stop_reg;
    logic       out_valid_reg, out_valid_next;
    c39_elem_t  out_reg;

    logic       emit;
    logic       finish;
    logic       gap;
    logic [3:0] pos;
    logic [8:0] cur_pat;
    c39_elem_t  cur;

    // An element leaves the sequencer whenever it is busy and the output register is free or being read
    assign emit     = busy_reg && (!out_valid_reg || elem_ready);
    assign job_take = job_valid && (!busy_reg || finish);

    // Build the current element
    always_comb
    begin
        cur_pat = (phase_reg == PH_CHAR) ? pat_reg : STAR_PATTERN;
        gap     = (idx_reg == GAP_ELEM);
        pos     = gap ? 4'd0 : (LAST_ELEM - idx_reg);
        cur     = '0;
        finish  = 1'b0;
        if (phase_reg == PH_ERR) begin
            cur.bad_char    = 1'b1;
            cur.last_of_run = 1'b1;
            finish          = emit;
        end else begin
            cur.is_bar   = !gap && !idx_reg[0];
            cur.is_wide  = gap || cur_pat[pos];
            cur.width_px = cur.is_wide ? wide_width : narrow_width;
            if (phase_reg == PH_STOP && idx_reg == LAST_ELEM) begin
                cur.symbol_done = 1'b1;
                cur.last_of_run = 1'b1;
                finish          = emit;
            end else if (phase_reg == PH_CHAR && gap && !stop_reg) begin
                cur.last_of_run = 1'b1;
                finish          = emit;
            end
        end
    end

    // Phase and element count
    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        if (emit) begin
            idx_next = idx_reg + 4'd1;
            if (phase_reg == PH_START && gap) begin
                phase_next = PH_CHAR;
                idx_next   = 4'd0;
            end else if (phase_reg == PH_CHAR && gap) begin
                phase_next = PH_STOP;
                idx_next   = 4'd0;
            end
        end
        if (finish) begin
            busy_next = 1'b0;
        end
        if (job_take) begin
            busy_next = 1'b1;
            idx_next  = 4'd0;
            if (job.bad) begin
                phase_next = PH_ERR;
            end else if (job.start) begin
                phase_next = PH_START;
            end else begin
                phase_next = PH_CHAR;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (elem_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            phase_reg     <= PH_ERR;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (job_take) begin
            pat_reg  <= job.pat;
            stop_reg <= job.stop;
        end
        if (emit) begin
            out_reg <= cur;
        end
    end

    assign elem_valid = out_valid_reg;
    assign elem       = out_reg;

endmodule

`default_nettype wire

@@ design/code39_bar_element_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Code 39 element generator. Each input word carries one ASCII character
// (tlast marks the end of the message) and expands into bar and space
// elements, one output word per cycle while m_axis_tready is high and input
// keeps up: the first character of a message is preceded by the start symbol
// and its gap (10 words), each character gives 10 words, and the last
// character is followed by the 9-word stop symbol. A character outside the
// Code 39 set gives one error word and the rest of the message is dropped
// without output. The rate is set by the element sequencer, which emits one
// element per cycle while the output is ready and a decoded character is
// waiting. One decoded character is held ahead of the sequencer, so the next
// input word is taken while the current one is still being emitted.
module code39_bar_element_generator (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] ch
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [15:0]     m_axis_tdata,  // [0] is_bar, [1] is_wide, [9:2] width_px,
                                           // [10] symbol_done, [15:11] zero
    output logic            m_axis_tuser,  // [0] bad_char
    output logic            m_axis_tlast
);
    import c39_pkg::*;

    logic [7:0] narrow_reg;
    logic [7:0] wide_reg;
    logic [1:0] mode_reg, mode_next;
    logic       job_valid_reg, job_valid_next;
    c39_job_t   job_reg, job_next;

    logic       in_accept;
    logic       job_take;
    logic       load_job;
    c39_index_t dec;
    logic       elem_valid;
    c39_elem_t  elem;

    // Width registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            narrow_reg <= 8'd1;
            wide_reg   <= 8'd3;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NARROW: narrow_reg <= cfg_data;
                CFG_WIDE:   wide_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign s_axis_tready = !job_valid_reg || job_take;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Decode the character and track the message state
    always_comb
    begin
        dec       = c39_char_index(s_axis_tdata);
        mode_next = mode_reg;
        load_job  = 1'b0;
        job_next  = '0;
        if (in_accept) begin
            if (mode_reg == MODE_DISCARD) begin
                if (s_axis_tlast) begin
                    mode_next = MODE_IDLE;
                end
            end else if (!dec.valid) begin
                load_job     = 1'b1;
                job_next.bad = 1'b1;
                mode_next    = s_axis_tlast ? MODE_IDLE : MODE_DISCARD;
            end else begin
                load_job       = 1'b1;
                job_next.start = (mode_reg != MODE_OPEN);
                job_next.stop  = s_axis_tlast;
                job_next.pat   = C39_PATTERNS[dec.index];
                mode_next      = s_axis_tlast ? MODE_IDLE : MODE_OPEN;
            end
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (load_job) begin
            job_valid_next = 1'b1;
        end else if (job_take) begin
            job_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_IDLE;
            job_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_job) begin
            job_reg <= job_next;
        end
    end

    c39_elem_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid_reg),
        .job          (job_reg),
        .job_take     (job_take),
        .narrow_width (narrow_reg),
        .wide_width   (wide_reg),
        .elem_valid   (elem_valid),
        .elem         (elem),
        .elem_ready   (m_axis_tready)
    );

    // Output word packing
    assign m_axis_tvalid = elem_valid;
    assign m_axis_tdata  = {5'd0, elem.symbol_done, elem.width_px, elem.is_wide, elem.is_bar};
    assign m_axis_tuser  = elem.bad_char;
    assign m_axis_tlast  = elem.last_of_run;

`ifndef NO_ASSERTIONS
    // An error word ends its run and carries no element
    a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 16'd0)
        else $error("error word malformed");

    // The stop symbol ends on a narrow bar that closes the run
    a_stop_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[10] |->
            m_axis_tlast && m_axis_tdata[0] && !m_axis_tdata[1])
        else $error("stop symbol end malformed");

    // A pending character is never dropped before the sequencer takes it
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_take |=> job_valid_reg && $stable(job_reg))
        else $error("pending character lost");
`endif

endmodule

`default_nettype wire
